[design/loop_record_segmenter_defines.svh]
// Assertion macros for the loop record segmenter.
`ifndef LOOP_RECORD_SEGMENTER_DEFINES_SVH
`define LOOP_RECORD_SEGMENTER_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define LRS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent true implies consequent on the next clock edge.
`define LRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lrs_pkg.sv]
package lrs_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int POS_W        = 32;
  localparam int DIV_CNT_W    = $clog2(POS_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } lrs_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } lrs_cmd_t;

  typedef struct packed {
    logic skip;      // empty range or empty loop
    logic need_div;  // range starts at or after loop start
    logic div_done;  // final remainder step this cycle
    logic seg_last;  // segment being emitted is the final one
  } lrs_sts_t;

endpackage

[design/lrs_ctrl.sv]
module lrs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  lrs_pkg::lrs_sts_t sts,
  output lrs_pkg::lrs_cmd_t cmd,
  output logic            busy
);

  lrs_pkg::lrs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    busy         = 1'b1;
    case (state_r)
      lrs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (!sts.skip) begin
            state_nxt = sts.need_div ? lrs_pkg::ST_DIV : lrs_pkg::ST_EMIT;
          end
        end
      end
      lrs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = lrs_pkg::ST_EMIT;
        end
      end
      lrs_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.seg_last) begin
          state_nxt = lrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/lrs_datapath.sv]
module lrs_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lrs_pkg::lrs_cmd_t          cmd,
  output lrs_pkg::lrs_sts_t          sts,
  input  logic [lrs_pkg::POS_W-1:0]  in_raw_start,
  input  logic [lrs_pkg::POS_W-1:0]  in_total_length,
  input  logic [lrs_pkg::POS_W-1:0]  in_loop_start,
  input  logic [lrs_pkg::POS_W-1:0]  in_loop_length,
  output logic                       out_valid,
  output logic [lrs_pkg::POS_W-1:0]  out_source_offset,
  output logic [lrs_pkg::POS_W-1:0]  out_segment_length,
  output logic [lrs_pkg::POS_W:0]    out_logical_start,
  output logic                       out_in_loop,
  output logic                       out_last,
  output logic                       out_truncated
);

  localparam int W = lrs_pkg::POS_W;

  logic [W-1:0]                   rs_r, ls_r, ll_r, left_r, done_r, rem_r, dvd_r;
  logic [lrs_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [lrs_pkg::SEG_CNT_W-1:0]  seg_n_r;
  logic                           pre_r;
  logic                           valid_r;
  logic [W-1:0]                   src_r, len_r;
  logic [W:0]                     place_r;
  logic                           inloop_r, last_r, trunc_r;

  logic [W-1:0] gap, room, lim, len;
  logic [W:0]   place, trial, diff;
  logic [W-1:0] rem_step;
  logic         fin, cap, ge;

  // segment length and placement from current state
  assign gap   = ls_r - rs_r;
  assign room  = ll_r - rem_r;
  assign lim   = pre_r ? gap : room;
  assign len   = (left_r < lim) ? left_r : lim;
  assign place = pre_r ? {1'b0, rs_r} : ({1'b0, ls_r} + {1'b0, rem_r});
  assign fin   = (len == left_r);
  assign cap   = (seg_n_r == lrs_pkg::SEG_CNT_W'(lrs_pkg::MAX_SEGMENTS - 1));

  // one restoring remainder step
  assign trial    = {rem_r, dvd_r[W-1]};
  assign ge       = (trial >= {1'b0, ll_r});
  assign diff     = trial - {1'b0, ll_r};
  assign rem_step = ge ? diff[W-1:0] : trial[W-1:0];

  always_comb begin
    sts.skip     = (in_total_length == '0) || (in_loop_length == '0);
    sts.need_div = (in_raw_start >= in_loop_start);
    sts.div_done = (cnt_r == '0);
    sts.seg_last = fin || cap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rs_r    <= in_raw_start;
      ls_r    <= in_loop_start;
      ll_r    <= in_loop_length;
      left_r  <= in_total_length;
      done_r  <= '0;
      rem_r   <= '0;
      dvd_r   <= in_raw_start - in_loop_start;
      cnt_r   <= '1;
      seg_n_r <= '0;
      pre_r   <= (in_raw_start < in_loop_start);
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end else if (cmd.emit) begin
      src_r    <= done_r;
      len_r    <= len;
      place_r  <= place;
      inloop_r <= !pre_r;
      last_r   <= fin || cap;
      trunc_r  <= cap && !fin;
      done_r   <= done_r + len;
      left_r   <= left_r - len;
      rem_r    <= '0;
      pre_r    <= 1'b0;
      seg_n_r  <= seg_n_r + 1'b1;
    end
  end

  assign out_valid          = valid_r;
  assign out_source_offset  = src_r;
  assign out_segment_length = len_r;
  assign out_logical_start  = place_r;
  assign out_in_loop        = inloop_r;
  assign out_last           = last_r;
  assign out_truncated      = trunc_r;

endmodule

[design/loop_record_segmenter.sv]
// Channel   Direction  Ports                                   Handshake
// input     in         in_raw_start, in_total_length,          start & !busy
//                      in_loop_start, in_loop_length
// result    out        out_source_offset, out_segment_length,  out_valid strobe,
//                      out_logical_start, out_in_loop,         one cycle each
//                      out_last, out_truncated
//
// Sequence: the accept cycle, then 32 remainder steps of the serial divider when
// the range starts at or after the loop start, then one segment per cycle;
// the divide is skipped when a plain pre-loop segment comes first.
// An empty range or empty loop frees the block right after the accept cycle.
// Each result is registered and shows in the cycle after it is formed; the next
// item may be taken while the final result is still on the ports.
// Reset: rst_n synchronous, active low; clears the controller and the strobe.
// Stalls: the receiver cannot stall, so results never wait.
`include "loop_record_segmenter_defines.svh"

module loop_record_segmenter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lrs_pkg::POS_W-1:0]  in_raw_start,
  input  logic [lrs_pkg::POS_W-1:0]  in_total_length,
  input  logic [lrs_pkg::POS_W-1:0]  in_loop_start,
  input  logic [lrs_pkg::POS_W-1:0]  in_loop_length,
  output logic                       out_valid,
  output logic [lrs_pkg::POS_W-1:0]  out_source_offset,
  output logic [lrs_pkg::POS_W-1:0]  out_segment_length,
  output logic [lrs_pkg::POS_W:0]    out_logical_start,
  output logic                       out_in_loop,
  output logic                       out_last,
  output logic                       out_truncated
);

  lrs_pkg::lrs_cmd_t cmd;
  lrs_pkg::lrs_sts_t sts;

  // sequencer: idle -> remainder loop (optional) -> one segment per cycle
  lrs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // item registers, serial remainder and segment arithmetic
  lrs_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_raw_start       (in_raw_start),
    .in_total_length    (in_total_length),
    .in_loop_start      (in_loop_start),
    .in_loop_length     (in_loop_length),
    .out_valid          (out_valid),
    .out_source_offset  (out_source_offset),
    .out_segment_length (out_segment_length),
    .out_logical_start  (out_logical_start),
    .out_in_loop        (out_in_loop),
    .out_last           (out_last),
    .out_truncated      (out_truncated)
  );

  // segments are never empty
  `LRS_ASSERT(a_len_nonzero, !out_valid || (out_segment_length != '0), "empty segment")
  // truncation is flagged only on the final segment
  `LRS_ASSERT(a_trunc_last, !out_truncated || !out_valid || out_last, "truncated not last")
  // more segments pending means the block is still working
  `LRS_ASSERT(a_busy_mid, !(out_valid && !out_last) || busy, "idle mid item")
  // an empty item frees the block at once
  `LRS_ASSERT_NEXT(a_skip_idle,
    start && !busy && ((in_total_length == '0) || (in_loop_length == '0)),
    !busy && !out_valid, "empty item kept block busy")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int POS_W        = lrs_pkg::POS_W;
  localparam int MAX_SEGMENTS = lrs_pkg::MAX_SEGMENTS;
  // width of a field as the checker compares it
  localparam int FW           = lrs_pkg::POS_W + 1;

  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is a 32-step divide plus a short sender gap, so this is
  // far beyond it.
  localparam int HANG_LIMIT   = 2000;
  // Hold-off after the last segment: accept + divide + a full capped burst.
  localparam int TAIL_CYCLES  = 1 + POS_W + MAX_SEGMENTS + 8;
  localparam int RANDOM_ITEMS = 70;

  typedef struct packed {
    logic [POS_W-1:0] src_off;
    logic [POS_W-1:0] seg_len;
    logic [POS_W:0]   place;
    logic             in_loop;
    logic             last;
    logic             trunc;
  } segment_t;

  // Predicts the segment list of each accepted item and checks the DUT's
  // segments in order against it.
  class segment_scoreboard;
    segment_t expected_q[$];
    int       errors = 0;

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [POS_W-1:0] rs, logic [POS_W-1:0] total,
                            logic [POS_W-1:0] ls, logic [POS_W-1:0] ll);
      // all sums one bit wider than a position, so nothing wraps
      logic [POS_W:0] done, pos, left, len, gap, phase, room;
      logic [POS_W:0] rs_w, total_w, ls_w, ll_w;
      segment_t seg;
      int n;
      rs_w    = {1'b0, rs};
      total_w = {1'b0, total};
      ls_w    = {1'b0, ls};
      ll_w    = {1'b0, ll};
      if (total == 0 || ll == 0)
        return;
      done = '0;
      n    = 0;
      while (done < total_w && n < MAX_SEGMENTS) begin
        pos  = rs_w + done;
        left = total_w - done;
        if (pos < ls_w) begin
          // plain part ahead of the loop
          gap         = ls_w - pos;
          len         = (left < gap) ? left : gap;
          seg.place   = pos;
          seg.in_loop = 1'b0;
        end else begin
          // fold into the loop, cut at the next loop boundary
          phase       = (pos - ls_w) % ll_w;
          room        = ll_w - phase;
          len         = (left < room) ? left : room;
          seg.place   = ls_w + phase;
          seg.in_loop = 1'b1;
        end
        seg.src_off = done[POS_W-1:0];
        seg.seg_len = len[POS_W-1:0];
        seg.last    = 1'b0;
        seg.trunc   = 1'b0;
        expected_q  = {expected_q, seg};
        n++;
        done = done + len;
      end
      seg        = expected_q.pop_back();
      seg.last   = 1'b1;
      seg.trunc  = (done < total_w);
      expected_q = {expected_q, seg};
    endfunction

    function bit field_ok(string name, logic [FW-1:0] exp_v, logic [FW-1:0] act_v);
      if (exp_v == act_v)
        return 1'b1;
      $display("%0t ERROR %s: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      return 1'b0;
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      bit ok;
      if (expected_q.size() == 0) begin
        $display("%0t ERROR unexpected segment: expected none, actual off 0x%0h len 0x%0h",
                 $time, got.src_off, got.seg_len);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      ok = field_ok("source_offset", FW'(want.src_off), FW'(got.src_off))
         & field_ok("segment_length", FW'(want.seg_len), FW'(got.seg_len))
         & field_ok("logical_start", want.place, got.place)
         & field_ok("in_loop", FW'(want.in_loop), FW'(got.in_loop))
         & field_ok("last", FW'(want.last), FW'(got.last))
         & field_ok("truncated", FW'(want.trunc), FW'(got.trunc));
      if (!ok)
        errors++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [POS_W-1:0] in_raw_start = '0;
  logic [POS_W-1:0] in_total_length = '0;
  logic [POS_W-1:0] in_loop_start = '0;
  logic [POS_W-1:0] in_loop_length = '0;
  logic             out_valid;
  logic [POS_W-1:0] out_source_offset;
  logic [POS_W-1:0] out_segment_length;
  logic [POS_W:0]   out_logical_start;
  logic             out_in_loop;
  logic             out_last;
  logic             out_truncated;

  segment_scoreboard sb = new();
  int                hang_cnt = 0;

  always #2 clk = ~clk;

  loop_record_segmenter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_start       (in_raw_start),
    .in_total_length    (in_total_length),
    .in_loop_start      (in_loop_start),
    .in_loop_length     (in_loop_length),
    .out_valid          (out_valid),
    .out_source_offset  (out_source_offset),
    .out_segment_length (out_segment_length),
    .out_logical_start  (out_logical_start),
    .out_in_loop        (out_in_loop),
    .out_last           (out_last),
    .out_truncated      (out_truncated)
  );

  // Result monitor: the strobe is sampled at the edge that ends its cycle.
  always @(posedge clk) begin
    segment_t got;
    if (rst_n && out_valid) begin
      got.src_off = out_source_offset;
      got.seg_len = out_segment_length;
      got.place   = out_logical_start;
      got.in_loop = out_in_loop;
      got.last    = out_last;
      got.trunc   = out_truncated;
      sb.check_segment(got);
    end
  end

  // Watchdog: any accepted item or segment restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("%0t hang: no handshake for %0d cycles", $time, HANG_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  // Present one item and hold it until the edge that takes it. start stays
  // high on return; the caller either presents the next item or drops it.
  task automatic send_item(logic [POS_W-1:0] rs, logic [POS_W-1:0] total,
                           logic [POS_W-1:0] ls, logic [POS_W-1:0] ll);
    in_raw_start    <= rs;
    in_total_length <= total;
    in_loop_start   <= ls;
    in_loop_length  <= ll;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(rs, total, ls, ll);
  endtask

  // Sender gap, taken in pct percent of the calls.
  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop sending until every predicted segment has been seen.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  task automatic run_directed();
    // empty range, empty loop, both
    send_item(32'd10, 32'd0, 32'd0, 32'd5);
    send_item(32'd10, 32'd20, 32'd0, 32'd0);
    send_item(32'd0, 32'd0, 32'd0, 32'd0);
    // whole range before the loop
    sender_gap(18);
    send_item(32'd100, 32'd50, 32'd1000, 32'd64);
    // plain part, then folded pieces
    send_item(32'd90, 32'd50, 32'd100, 32'd16);
    // starts right on the loop start
    send_item(32'd100, 32'd40, 32'd100, 32'd16);
    // starts well past the loop, odd loop length
    sender_gap(18);
    send_item(32'd1000, 32'd33, 32'd100, 32'd7);
    // single sample, single-sample loop
    send_item(32'd5, 32'd1, 32'd5, 32'd1);
    // cap: far too many pieces, exactly at the cap, cap with a plain part
    send_item(32'd0, 32'd1000, 32'd0, 32'd1);
    send_item(32'd0, 32'd64, 32'd0, 32'd1);
    send_item(32'd0, 32'd65, 32'd0, 32'd1);
    sender_gap(18);
    send_item(32'd0, 32'd73, 32'd10, 32'd1);
    send_item(32'd0, 32'd74, 32'd10, 32'd1);
    // all-ones fields
    send_item('1, '1, '1, '1);
    send_item('1, '1, 32'd0, 32'd3);
    send_item(32'd0, '1, '1, '1);
    send_item('1, '1, 32'h8000_0000, '1);
    send_item('1, 32'd100, 32'hF000_0000, 32'h2000_0000);
    send_item(32'd0, '1, 32'd0, '1);
    send_item('1, 32'd1, '1, 32'd1);
  endtask

  // Random items; empty ones are sent too but do not count toward the total.
  task automatic run_random();
    logic [POS_W-1:0] rs, total, ls, ll;
    int               counted;
    int               pct;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // three idling regimes: light, heavy, none
      pct = (counted < RANDOM_ITEMS / 3) ? 18 : (counted < 2 * RANDOM_ITEMS / 3) ? 69 : 0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // compact ranges around a short loop
          rs    = $urandom_range(0, 3000);
          ls    = $urandom_range(0, 3000);
          ll    = $urandom_range(1, 40);
          total = $urandom_range(1, 800);
        end
        4, 5: begin
          // any bit pattern
          rs    = $urandom();
          total = $urandom();
          ls    = $urandom();
          ll    = $urandom();
        end
        6: begin
          // near the top of the timeline, usually capped
          rs    = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
          ls    = rs - $urandom_range(0, 1000);
          ll    = $urandom_range(1, 300);
          total = $urandom();
        end
        7: begin
          // right around the segment cap
          rs    = $urandom();
          ls    = rs;
          ll    = $urandom_range(1, 8);
          total = ll * MAX_SEGMENTS - 1 + $urandom_range(0, 2);
        end
        8: begin
          // plain part ahead of the loop, then folding
          rs    = $urandom_range(0, 32'h7FFF_FFFF);
          ls    = rs + $urandom_range(1, 1000);
          ll    = $urandom_range(1, 100);
          total = $urandom_range(1, 5000);
        end
        default: begin
          // nothing to emit
          rs    = $urandom();
          ls    = $urandom();
          total = $urandom_range(0, 1) ? 32'd0 : $urandom();
          ll    = (total == 0) ? $urandom() : 32'd0;
        end
      endcase
      sender_gap(pct);
      send_item(rs, total, ls, ll);
      if (total != 0 && ll != 0) begin
        counted++;
        // one full pause mid-run
        if (counted == RANDOM_ITEMS / 2)
          drain();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    run_random();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
